@@ src/svpwm_pkg.sv @@
// shared types and constants of the svpwm duty generator
package svpwm_pkg;

  localparam int DATA_W = 16;
  localparam int LIM_W  = 15;
  localparam int RAD_W  = 48;
  localparam int ROOT_W = 24;
  localparam int NUM_W  = 39;
  localparam int QUO_W  = 16;
  localparam int V_W    = 34;
  localparam int D_W    = 37;
  localparam int RND_W  = 21;

  localparam logic signed [DATA_W-1:0] SQRT3_HALF = 16'sd28378;

  localparam logic [2:0] QUAD_PP = 3'd1;
  localparam logic [2:0] QUAD_NP = 3'd3;
  localparam logic [2:0] QUAD_NN = 3'd4;
  localparam logic [2:0] QUAD_PN = 3'd6;

  localparam logic [1:0] REG_LIMIT = 2'd0;
  localparam logic [1:0] REG_DMIN  = 2'd1;
  localparam logic [1:0] REG_DMAX  = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] alpha_voltage;
    logic signed [DATA_W-1:0] beta_voltage;
    logic signed [DATA_W-1:0] shift_common;
  } svpwm_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] duty_a;
    logic [DATA_W-1:0] duty_b;
    logic [DATA_W-1:0] duty_c;
    logic [2:0]        quadrant_code;
  } svpwm_out_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] alpha;
    logic signed [DATA_W-1:0] beta;
    logic signed [DATA_W-1:0] shift;
    logic                     lim;
    logic [2:0]               code;
  } svpwm_side_t;

  typedef struct packed {
    logic vld;
    logic en;
  } svpwm_ctl_t;

endpackage

@@ src/svpwm_duty_generator_unit.sv @@
// svpwm duty generator: limiting, inverse clarke, min-max injection, clamp
// throughput: one request per cycle; the whole pipeline stalls as one while
// a result waits at the output register
// the 24-stage root and 16-stage divider set the depth
// reset (synchronous, active low) empties the pipeline and loads the registers
module svpwm_duty_generator_unit import svpwm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  svpwm_in_t         in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output svpwm_out_t        out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [DATA_W-1:0] cfg_wdata
);

  logic [LIM_W-1:0]  limit_r;
  logic [DATA_W-1:0] dmin_r;
  logic [DATA_W-1:0] dmax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
      dmin_r  <= '0;
      dmax_r  <= 16'd32768;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIMIT: limit_r <= cfg_wdata[LIM_W-1:0];
        REG_DMIN:  dmin_r  <= cfg_wdata;
        REG_DMAX:  dmax_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic       en;
  svpwm_ctl_t ctl_sq;
  svpwm_ctl_t ctl_dv;
  logic       out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // stage 0: input register
  logic      s0_vld_r;
  svpwm_in_t s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= in_data;
    end
  end

  // stage 1: squares, |x| * limit products, limit squared and quadrant code
  logic signed [31:0] sq_a;
  logic signed [31:0] sq_b;
  logic [16:0]        abs_a;
  logic [16:0]        abs_b;
  logic [31:0]        lp_a;
  logic [31:0]        lp_b;
  logic [29:0]        ll;
  logic [2:0]         code;
  svpwm_side_t        s1_side;

  always_comb begin
    sq_a  = s0_r.alpha_voltage * s0_r.alpha_voltage;
    sq_b  = s0_r.beta_voltage * s0_r.beta_voltage;
    abs_a = s0_r.alpha_voltage[15] ? 17'(-$signed({s0_r.alpha_voltage[15], s0_r.alpha_voltage}))
                                    : {1'b0, s0_r.alpha_voltage};
    abs_b = s0_r.beta_voltage[15] ? 17'(-$signed({s0_r.beta_voltage[15], s0_r.beta_voltage}))
                                  : {1'b0, s0_r.beta_voltage};
    lp_a  = abs_a * limit_r;
    lp_b  = abs_b * limit_r;
    ll    = limit_r * limit_r;
    unique case ({s0_r.beta_voltage[15], s0_r.alpha_voltage[15]})
      2'b00:   code = QUAD_PP;
      2'b01:   code = QUAD_NP;
      2'b10:   code = QUAD_PN;
      default: code = QUAD_NN;
    endcase
    s1_side.alpha = s0_r.alpha_voltage;
    s1_side.beta  = s0_r.beta_voltage;
    s1_side.shift = s0_r.shift_common;
    s1_side.lim   = 1'b0;
    s1_side.code  = code;
  end

  logic              s1_vld_r;
  logic [30:0]       s1_sqa_r;
  logic [30:0]       s1_sqb_r;
  logic [29:0]       s1_lpa_r;
  logic [29:0]       s1_lpb_r;
  logic [29:0]       s1_ll_r;
  svpwm_side_t       s1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sqa_r  <= sq_a[30:0];
      s1_sqb_r  <= sq_b[30:0];
      s1_lpa_r  <= lp_a[29:0];
      s1_lpb_r  <= lp_b[29:0];
      s1_ll_r   <= ll;
      s1_side_r <= s1_side;
    end
  end

  // stage 2: magnitude squared and limit decision
  logic [31:0] mag_sq;
  svpwm_side_t s2_side;

  assign mag_sq = {1'b0, s1_sqa_r} + {1'b0, s1_sqb_r};

  always_comb begin
    s2_side     = s1_side_r;
    s2_side.lim = (limit_r != '0) && (mag_sq > {2'b00, s1_ll_r});
  end

  logic             s2_vld_r;
  logic [31:0]      s2_s_r;
  logic [NUM_W-1:0] s2_na_r;
  logic [NUM_W-1:0] s2_nb_r;
  svpwm_side_t      s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_s_r    <= mag_sq;
      s2_na_r   <= NUM_W'({s1_lpa_r, 8'b0});
      s2_nb_r   <= NUM_W'({s1_lpb_r, 8'b0});
      s2_side_r <= s2_side;
    end
  end

  // magnitude root and component divide
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  svpwm_side_t       sq_side;
  logic [NUM_W-1:0]  sq_na;
  logic [NUM_W-1:0]  sq_nb;

  assign ctl_sq.vld = s2_vld_r;
  assign ctl_sq.en  = en;

  svpwm_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_sq),
    .rad       ({s2_s_r, 16'b0}),
    .side_in   (s2_side_r),
    .num_a_in  (s2_na_r),
    .num_b_in  (s2_nb_r),
    .vld_out   (sq_vld),
    .root_out  (sq_root),
    .side_out  (sq_side),
    .num_a_out (sq_na),
    .num_b_out (sq_nb)
  );

  logic             dv_vld;
  logic [QUO_W-1:0] dv_qa;
  logic [QUO_W-1:0] dv_qb;
  svpwm_side_t      dv_side;

  assign ctl_dv.vld = sq_vld;
  assign ctl_dv.en  = en;

  svpwm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl_dv),
    .num_a    (sq_na),
    .num_b    (sq_nb),
    .den      (sq_root),
    .side_in  (sq_side),
    .vld_out  (dv_vld),
    .quo_a    (dv_qa),
    .quo_b    (dv_qb),
    .side_out (dv_side)
  );

  // stage c: pick limited components, inverse clarke
  logic signed [DATA_W-1:0] a_l;
  logic signed [DATA_W-1:0] b_l;
  logic signed [31:0]       kb;
  logic signed [V_W-1:0]    va;
  logic signed [V_W-1:0]    ah;

  always_comb begin
    if (dv_side.lim) begin
      a_l = dv_side.alpha[15] ? -$signed(dv_qa) : $signed(dv_qa);
      b_l = dv_side.beta[15] ? -$signed(dv_qb) : $signed(dv_qb);
    end else begin
      a_l = dv_side.alpha;
      b_l = dv_side.beta;
    end
    kb = SQRT3_HALF * b_l;
    va = V_W'(a_l) <<< 15;
    ah = V_W'(a_l) <<< 14;
  end

  logic                     sc_vld_r;
  logic signed [V_W-1:0]    sc_va_r;
  logic signed [V_W-1:0]    sc_vb_r;
  logic signed [V_W-1:0]    sc_vc_r;
  logic signed [DATA_W-1:0] sc_sh_r;
  logic [2:0]               sc_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_vld_r <= 1'b0;
    end else if (en) begin
      sc_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_va_r   <= va;
      sc_vb_r   <= V_W'(kb) - ah;
      sc_vc_r   <= -ah - V_W'(kb);
      sc_sh_r   <= dv_side.shift;
      sc_code_r <= dv_side.code;
    end
  end

  // stage m: max plus min
  logic signed [V_W-1:0] vmax;
  logic signed [V_W-1:0] vmin;

  always_comb begin
    vmax = sc_va_r;
    if (sc_vb_r > vmax) vmax = sc_vb_r;
    if (sc_vc_r > vmax) vmax = sc_vc_r;
    vmin = sc_va_r;
    if (sc_vb_r < vmin) vmin = sc_vb_r;
    if (sc_vc_r < vmin) vmin = sc_vc_r;
  end

  logic                     sm_vld_r;
  logic signed [V_W-1:0]    sm_va_r;
  logic signed [V_W-1:0]    sm_vb_r;
  logic signed [V_W-1:0]    sm_vc_r;
  logic signed [V_W:0]      sm_sum_r;
  logic signed [DATA_W-1:0] sm_sh_r;
  logic [2:0]               sm_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_vld_r <= 1'b0;
    end else if (en) begin
      sm_vld_r <= sc_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm_va_r   <= sc_va_r;
      sm_vb_r   <= sc_vb_r;
      sm_vc_r   <= sc_vc_r;
      sm_sum_r  <= (V_W+1)'(vmax) + (V_W+1)'(vmin);
      sm_sh_r   <= sc_sh_r;
      sm_code_r <= sc_code_r;
    end
  end

  // stage d: injection, offset, shift and round half up
  logic signed [D_W-1:0] dbase;
  logic signed [D_W-1:0] da;
  logic signed [D_W-1:0] db;
  logic signed [D_W-1:0] dc;

  always_comb begin
    dbase = (D_W'(sm_sh_r) <<< 16) - D_W'(sm_sum_r) + (D_W'(1) <<< 30) + (D_W'(1) <<< 15);
    da    = (D_W'(sm_va_r) <<< 1) + dbase;
    db    = (D_W'(sm_vb_r) <<< 1) + dbase;
    dc    = (D_W'(sm_vc_r) <<< 1) + dbase;
  end

  logic                    sd_vld_r;
  logic signed [RND_W-1:0] sd_ra_r;
  logic signed [RND_W-1:0] sd_rb_r;
  logic signed [RND_W-1:0] sd_rc_r;
  logic [2:0]              sd_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_vld_r <= 1'b0;
    end else if (en) begin
      sd_vld_r <= sm_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_ra_r   <= da[D_W-1:16];
      sd_rb_r   <= db[D_W-1:16];
      sd_rc_r   <= dc[D_W-1:16];
      sd_code_r <= sm_code_r;
    end
  end

  // output stage: clamp, min wins over max
  function automatic logic [DATA_W-1:0] clamp_duty(
    input logic signed [RND_W-1:0] r,
    input logic [DATA_W-1:0]       lo,
    input logic [DATA_W-1:0]       hi
  );
    logic signed [RND_W-1:0] slo;
    logic signed [RND_W-1:0] shi;
    logic [DATA_W-1:0]       res;
    slo = $signed(RND_W'(lo));
    shi = $signed(RND_W'(hi));
    priority if (r < slo) begin
      res = lo;
    end else if (r > shi) begin
      res = hi;
    end else begin
      res = r[DATA_W-1:0];
    end
    return res;
  endfunction

  svpwm_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.duty_a        <= clamp_duty(sd_ra_r, dmin_r, dmax_r);
      out_data_r.duty_b        <= clamp_duty(sd_rb_r, dmin_r, dmax_r);
      out_data_r.duty_c        <= clamp_duty(sd_rc_r, dmin_r, dmax_r);
      out_data_r.quadrant_code <= sd_code_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/svpwm_sqrt.sv @@
// pipelined integer square root, one result bit per stage
module svpwm_sqrt import svpwm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  svpwm_ctl_t        ctl,
  input  logic [RAD_W-1:0]  rad,
  input  svpwm_side_t       side_in,
  input  logic [NUM_W-1:0]  num_a_in,
  input  logic [NUM_W-1:0]  num_b_in,
  output logic              vld_out,
  output logic [ROOT_W-1:0] root_out,
  output svpwm_side_t       side_out,
  output logic [NUM_W-1:0]  num_a_out,
  output logic [NUM_W-1:0]  num_b_out
);

  logic [RAD_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic              vld_r  [ROOT_W];
  svpwm_side_t       side_r [ROOT_W];
  logic [NUM_W-1:0]  na_r   [ROOT_W];
  logic [NUM_W-1:0]  nb_r   [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [RAD_W-1:0]  rem_cur;
    logic [ROOT_W-1:0] root_cur;
    logic              vld_cur;
    svpwm_side_t       side_cur;
    logic [NUM_W-1:0]  na_cur;
    logic [NUM_W-1:0]  nb_cur;
    logic [RAD_W+1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_cur  = rad;
      assign root_cur = '0;
      assign vld_cur  = ctl.vld;
      assign side_cur = side_in;
      assign na_cur   = num_a_in;
      assign nb_cur   = num_b_in;
    end else begin : g_next
      assign rem_cur  = rem_r[k-1];
      assign root_cur = root_r[k-1];
      assign vld_cur  = vld_r[k-1];
      assign side_cur = side_r[k-1];
      assign na_cur   = na_r[k-1];
      assign nb_cur   = nb_r[k-1];
    end

    // r^2 grows by (2r + 2^B) << B when bit B is set
    always_comb begin
      trial = ({{(RAD_W+1-ROOT_W){1'b0}}, root_cur, 1'b0} + ((RAD_W+2)'(1) << B)) << B;
      ge    = {2'b00, rem_cur} >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[k] <= vld_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_r[k]  <= ge ? (rem_cur - trial[RAD_W-1:0]) : rem_cur;
        root_r[k] <= root_cur | (ROOT_W'(ge) << B);
        side_r[k] <= side_cur;
        na_r[k]   <= na_cur;
        nb_r[k]   <= nb_cur;
      end
    end
  end

  assign vld_out   = vld_r[ROOT_W-1];
  assign root_out  = root_r[ROOT_W-1];
  assign side_out  = side_r[ROOT_W-1];
  assign num_a_out = na_r[ROOT_W-1];
  assign num_b_out = nb_r[ROOT_W-1];

endmodule

@@ src/svpwm_div.sv @@
// pipelined restoring divider, both components against one magnitude
module svpwm_div import svpwm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  svpwm_ctl_t        ctl,
  input  logic [NUM_W-1:0]  num_a,
  input  logic [NUM_W-1:0]  num_b,
  input  logic [ROOT_W-1:0] den,
  input  svpwm_side_t       side_in,
  output logic              vld_out,
  output logic [QUO_W-1:0]  quo_a,
  output logic [QUO_W-1:0]  quo_b,
  output svpwm_side_t       side_out
);

  logic [NUM_W-1:0]  ra_r   [QUO_W];
  logic [NUM_W-1:0]  rb_r   [QUO_W];
  logic [QUO_W-1:0]  qa_r   [QUO_W];
  logic [QUO_W-1:0]  qb_r   [QUO_W];
  logic [ROOT_W-1:0] den_r  [QUO_W];
  logic              vld_r  [QUO_W];
  svpwm_side_t       side_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int B = QUO_W - 1 - k;
    logic [NUM_W-1:0]  ra_cur;
    logic [NUM_W-1:0]  rb_cur;
    logic [QUO_W-1:0]  qa_cur;
    logic [QUO_W-1:0]  qb_cur;
    logic [ROOT_W-1:0] den_cur;
    logic              vld_cur;
    svpwm_side_t       side_cur;
    logic [NUM_W:0]    dsh;
    logic              ge_a;
    logic              ge_b;

    if (k == 0) begin : g_first
      assign ra_cur   = num_a;
      assign rb_cur   = num_b;
      assign qa_cur   = '0;
      assign qb_cur   = '0;
      assign den_cur  = den;
      assign vld_cur  = ctl.vld;
      assign side_cur = side_in;
    end else begin : g_next
      assign ra_cur   = ra_r[k-1];
      assign rb_cur   = rb_r[k-1];
      assign qa_cur   = qa_r[k-1];
      assign qb_cur   = qb_r[k-1];
      assign den_cur  = den_r[k-1];
      assign vld_cur  = vld_r[k-1];
      assign side_cur = side_r[k-1];
    end

    always_comb begin
      dsh  = (NUM_W+1)'(den_cur) << B;
      ge_a = {1'b0, ra_cur} >= dsh;
      ge_b = {1'b0, rb_cur} >= dsh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[k] <= vld_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        ra_r[k]   <= ge_a ? (ra_cur - dsh[NUM_W-1:0]) : ra_cur;
        rb_r[k]   <= ge_b ? (rb_cur - dsh[NUM_W-1:0]) : rb_cur;
        qa_r[k]   <= qa_cur | (QUO_W'(ge_a) << B);
        qb_r[k]   <= qb_cur | (QUO_W'(ge_b) << B);
        den_r[k]  <= den_cur;
        side_r[k] <= side_cur;
      end
    end
  end

  assign vld_out  = vld_r[QUO_W-1];
  assign quo_a    = qa_r[QUO_W-1];
  assign quo_b    = qb_r[QUO_W-1];
  assign side_out = side_r[QUO_W-1];

endmodule
